// ----- hdl/cmcc_pkg.sv -----
// Types and constants shared by the membership change checker.
// No dependencies.
package cmcc_pkg;

   localparam int RULE_COUNT = 11;

   typedef enum logic [1:0] {
      CMD_ADD_VOTER    = 2'd0,
      CMD_ADD_OBSERVER = 2'd1,
      CMD_ADD_WITNESS  = 2'd2,
      CMD_REMOVE       = 2'd3
   } command_type;

   localparam logic [1:0] ROLE_VOTER    = 2'd0;
   localparam logic [1:0] ROLE_OBSERVER = 2'd1;
   localparam logic [1:0] ROLE_WITNESS  = 2'd2;

   localparam int RULE_STALE        = 0;
   localparam int RULE_REMOVED      = 1;
   localparam int RULE_EXISTING     = 2;
   localparam int RULE_VOTER_AS_OBS = 3;
   localparam int RULE_VOTER_AS_WIT = 4;
   localparam int RULE_WIT_AS_VOTER = 5;
   localparam int RULE_WIT_AS_OBS   = 6;
   localparam int RULE_OBS_AS_WIT   = 7;
   localparam int RULE_LAST_VOTER   = 8;
   localparam int RULE_PROMOTION    = 9;
   localparam int RULE_FULL         = 10;

   typedef struct packed {
      command_type command;
      logic [63:0] node_id;
      logic [63:0] address_token;
      logic [63:0] expected_change_id;
      logic        initialize;
      logic [63:0] log_index;
   } req_type;

   typedef struct packed {
      logic                  accepted;
      logic [RULE_COUNT-1:0] reject_mask;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_MEMBER,
      ST_SCAN_REMOVED,
      ST_DECIDE,
      ST_REMOVE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_member;
      logic scan_removed;
      logic decide;
      logic remove_step;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic member_last;
      logic removed_last;
      logic accept;
      logic is_remove;
      logic remove_last;
   } status_type;

endpackage

// ----- hdl/cluster_membership_change_checker.sv -----
// Top level of the cluster membership change checker.
// Depends on cmcc_pkg, cmcc_ctrl and cmcc_dp.
// After accept it scans the member store, then the removed store, then decides;
// an accepted remove then walks the member store (one store entry per cycle).
// One request at a time: req_stall stays high until the response is taken.
// Reset: synchronous; clears both stores' valid bits, change id, voter count, mode.
module cluster_membership_change_checker
   import cmcc_pkg::*;
#(
   parameter int MEMBER_ENTRIES  = 16,
   parameter int REMOVED_ENTRIES = 16,
   parameter int ADDRESS_BITS    = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_write,
   input  logic    csr_data,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   cmcc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .status
   );

   cmcc_dp #(
      .MEMBER_ENTRIES(MEMBER_ENTRIES), .REMOVED_ENTRIES(REMOVED_ENTRIES),
      .ADDRESS_BITS(ADDRESS_BITS)
   ) u_dp (
      .clock, .reset, .csr_write, .csr_data, .req_data, .rsp_data, .cmd, .status
   );

endmodule

// ----- hdl/cmcc_ctrl.sv -----
// Sequencer of the membership change checker.
// Depends on cmcc_pkg.
module cmcc_ctrl
   import cmcc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:         if (req_valid) state_in = ST_SCAN_MEMBER;
         ST_SCAN_MEMBER:  if (status.member_last) state_in = ST_SCAN_REMOVED;
         ST_SCAN_REMOVED: if (status.removed_last) state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (status.accept && status.is_remove) state_in = ST_REMOVE;
            else state_in = ST_RESPOND;
         end
         ST_REMOVE:       if (status.remove_last) state_in = ST_RESPOND;
         ST_RESPOND:      if (!rsp_stall) state_in = ST_IDLE;
         default:         state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
         end
         ST_SCAN_MEMBER:  cmd.scan_member = 1'b1;
         ST_SCAN_REMOVED: cmd.scan_removed = 1'b1;
         ST_DECIDE:       cmd.decide = 1'b1;
         ST_REMOVE:       cmd.remove_step = 1'b1;
         ST_RESPOND: begin
            rsp_valid = 1'b1;
            cmd.respond = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   a_rsp_only_respond: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_RESPOND) else $error("rsp outside respond");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_SCAN_MEMBER)
      else $error("accept did not start scan");
   a_remove_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REMOVE) |-> $past(state_ff) == ST_DECIDE || $past(state_ff) == ST_REMOVE)
      else $error("bad remove entry");

endmodule

// ----- hdl/cmcc_dp.sv -----
// Datapath: member and removed stores, scan, rule check and update.
// Depends on cmcc_pkg.
module cmcc_dp
   import cmcc_pkg::*;
#(
   parameter int MEMBER_ENTRIES  = 16,
   parameter int REMOVED_ENTRIES = 16,
   parameter int ADDRESS_BITS    = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write,
   input  logic       csr_data,
   input  req_type    req_data,
   output rsp_type    rsp_data,
   input  cmd_type    cmd,
   output status_type status
);

   localparam int MW = (MEMBER_ENTRIES > 1) ? $clog2(MEMBER_ENTRIES) : 1;
   localparam int RW = (REMOVED_ENTRIES > 1) ? $clog2(REMOVED_ENTRIES) : 1;
   localparam int VW = $clog2(MEMBER_ENTRIES + 1);

   logic                    mode_ff;
   logic [MEMBER_ENTRIES-1:0]  mvalid_ff;
   logic [63:0]             mnode_ff [MEMBER_ENTRIES];
   logic [ADDRESS_BITS-1:0] maddr_ff [MEMBER_ENTRIES];
   logic [1:0]              mrole_ff [MEMBER_ENTRIES];
   logic [REMOVED_ENTRIES-1:0] rvalid_ff;
   logic [63:0]             rnode_ff [REMOVED_ENTRIES];
   logic [63:0]             applied_ff;
   logic [VW-1:0]           voters_ff;

   req_type                 req_ff;
   logic [ADDRESS_BITS-1:0] addr;
   logic [MW-1:0]           midx_ff;
   logic [RW-1:0]           ridx_ff;
   logic                    hit_ff, free_m_ff, clash_ff, in_rem_ff, free_r_ff;
   logic [MW-1:0]           hit_idx_ff, free_m_idx_ff;
   logic [RW-1:0]           free_r_idx_ff;
   logic [1:0]              hit_role_ff;
   logic [ADDRESS_BITS-1:0] hit_addr_ff;
   logic                    stale_ff;
   rsp_type                 rsp_ff;

   logic [RULE_COUNT-1:0]   mask;
   logic                    is_add, is_v, is_o, is_w, promo, same_addr, existing;
   command_type             c;

   assign addr = req_ff.address_token[ADDRESS_BITS-1:0];
   assign c = req_ff.command;
   assign is_add = c != CMD_REMOVE;
   assign is_v = hit_ff && hit_role_ff == ROLE_VOTER;
   assign is_o = hit_ff && hit_role_ff == ROLE_OBSERVER;
   assign is_w = hit_ff && hit_role_ff == ROLE_WITNESS;
   assign same_addr = hit_addr_ff == addr;
   assign promo = c == CMD_ADD_VOTER && is_o && same_addr;

   always_comb begin
      mask = '0;
      existing = (c == CMD_ADD_VOTER && is_v) || (c == CMD_ADD_OBSERVER && is_o)
              || (c == CMD_ADD_WITNESS && is_w) || (!promo && is_add && clash_ff);
      mask[RULE_STALE]        = stale_ff;
      mask[RULE_REMOVED]      = is_add && in_rem_ff;
      mask[RULE_EXISTING]     = existing;
      mask[RULE_VOTER_AS_OBS] = c == CMD_ADD_OBSERVER && is_v;
      mask[RULE_VOTER_AS_WIT] = c == CMD_ADD_WITNESS && is_v;
      mask[RULE_WIT_AS_VOTER] = c == CMD_ADD_VOTER && is_w;
      mask[RULE_WIT_AS_OBS]   = c == CMD_ADD_OBSERVER && is_w;
      mask[RULE_OBS_AS_WIT]   = c == CMD_ADD_WITNESS && is_o;
      mask[RULE_LAST_VOTER]   = c == CMD_REMOVE && voters_ff == VW'(1) && is_v;
      mask[RULE_PROMOTION]    = c == CMD_ADD_VOTER && is_o && !same_addr;
      mask[RULE_FULL]         = (is_add && !hit_ff && !free_m_ff)
                             || (!is_add && !in_rem_ff && !free_r_ff);
   end

   assign status.member_last  = midx_ff == MW'(MEMBER_ENTRIES - 1);
   assign status.removed_last = ridx_ff == RW'(REMOVED_ENTRIES - 1);
   assign status.accept       = mask == '0;
   assign status.is_remove    = !is_add;
   assign status.remove_last  = midx_ff == MW'(MEMBER_ENTRIES - 1);
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         mvalid_ff  <= '0;
         rvalid_ff  <= '0;
         applied_ff <= '0;
         voters_ff  <= '0;
      end else begin
         if (csr_write) mode_ff <= csr_data;
         if (cmd.decide && mask == '0) begin
            applied_ff <= req_ff.log_index;
            if (is_add) begin
               if (hit_ff) begin
                  if (hit_role_ff == ROLE_VOTER && voters_ff != '0 && c != CMD_ADD_VOTER)
                     voters_ff <= voters_ff - VW'(1);
                  else if (hit_role_ff != ROLE_VOTER && c == CMD_ADD_VOTER)
                     voters_ff <= voters_ff + VW'(1);
               end else if (c == CMD_ADD_VOTER) begin
                  voters_ff <= voters_ff + VW'(1);
               end
               if (hit_ff) mvalid_ff[hit_idx_ff] <= 1'b1;
               else mvalid_ff[free_m_idx_ff] <= 1'b1;
            end else if (!in_rem_ff) begin
               rvalid_ff[free_r_idx_ff] <= 1'b1;
            end
         end
         if (cmd.remove_step && mvalid_ff[midx_ff]
             && mnode_ff[midx_ff] == req_ff.node_id) begin
            mvalid_ff[midx_ff] <= 1'b0;
            if (mrole_ff[midx_ff] == ROLE_VOTER && voters_ff != '0)
               voters_ff <= voters_ff - VW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide && mask == '0) begin
         if (is_add) begin
            if (hit_ff) begin
               mnode_ff[hit_idx_ff] <= req_ff.node_id;
               maddr_ff[hit_idx_ff] <= addr;
               mrole_ff[hit_idx_ff] <= c;
            end else begin
               mnode_ff[free_m_idx_ff] <= req_ff.node_id;
               maddr_ff[free_m_idx_ff] <= addr;
               mrole_ff[free_m_idx_ff] <= c;
            end
         end else if (!in_rem_ff) begin
            rnode_ff[free_r_idx_ff] <= req_ff.node_id;
         end
      end
   end

   // scan and control-side registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff    <= req_data;
         midx_ff   <= '0;
         ridx_ff   <= '0;
         hit_ff    <= 1'b0;
         free_m_ff <= 1'b0;
         clash_ff  <= 1'b0;
         in_rem_ff <= 1'b0;
         free_r_ff <= 1'b0;
         stale_ff  <= mode_ff && !req_data.initialize
                   && applied_ff != req_data.expected_change_id;
      end
      if (cmd.scan_member) begin
         if (mvalid_ff[midx_ff]) begin
            if (!hit_ff && mnode_ff[midx_ff] == req_ff.node_id) begin
               hit_ff      <= 1'b1;
               hit_idx_ff  <= midx_ff;
               hit_role_ff <= mrole_ff[midx_ff];
               hit_addr_ff <= maddr_ff[midx_ff];
            end
            if (maddr_ff[midx_ff] == addr) clash_ff <= 1'b1;
         end else if (!free_m_ff) begin
            free_m_ff     <= 1'b1;
            free_m_idx_ff <= midx_ff;
         end
         midx_ff <= status.member_last ? '0 : midx_ff + MW'(1);
      end
      if (cmd.scan_removed) begin
         if (rvalid_ff[ridx_ff]) begin
            if (rnode_ff[ridx_ff] == req_ff.node_id) in_rem_ff <= 1'b1;
         end else if (!free_r_ff) begin
            free_r_ff     <= 1'b1;
            free_r_idx_ff <= ridx_ff;
         end
         ridx_ff <= status.removed_last ? '0 : ridx_ff + RW'(1);
      end
      if (cmd.decide) begin
         rsp_ff.accepted    <= mask == '0;
         rsp_ff.reject_mask <= mask;
      end
      if (cmd.remove_step)
         midx_ff <= status.remove_last ? '0 : midx_ff + MW'(1);
   end

   a_accept_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |=> rsp_ff.accepted == (rsp_ff.reject_mask == '0))
      else $error("accept flag disagrees with mask");
   a_voters_bound: assert property (@(posedge clock) disable iff (reset)
      voters_ff <= VW'($countones(mvalid_ff))) else $error("voter count too high");
   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && hit_ff) |-> mvalid_ff[hit_idx_ff]) else $error("hit on free entry");

endmodule
